/* rtl/row_record_decoder_core_defines.svh */
// ---------------------------------------------------------------------------
// Row record decoder assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ROW_RECORD_DECODER_CORE_DEFINES_SVH
`define ROW_RECORD_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RRD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("row decoder assertion failed");
`define RRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("row decoder assertion failed");
`else
`define RRD_ASSERT(lbl, clk, rst_n, prop)
`define RRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/rrd_pkg.sv */
// ---------------------------------------------------------------------------
// Row record decoder package
// Transaction types, result codes and state encodings.
// ---------------------------------------------------------------------------
`default_nettype none

package rrd_pkg;

    typedef struct packed {
        logic [7:0] row_byte;
        logic       end_of_row;
    } row_item_t;

    typedef struct packed {
        logic [2:0]         result_kind;
        logic [4:0]         column;
        logic signed [31:0] int_value;
        logic [7:0]         text_byte;
        logic [15:0]        text_length;
        logic               column_done;
        logic [1:0]         error_code;
        logic               last_result;
    } res_item_t;

    typedef struct packed {
        logic [5:0]  columns_in_use;
        logic [63:0] column_types;
        logic [21:0] text_space;
    } cfg_regs_t;

    typedef enum logic [2:0] {
        PH_HDR_LO,
        PH_HDR_HI,
        PH_NULLMAP,
        PH_INT,
        PH_TLEN_LO,
        PH_TLEN_HI,
        PH_TEXT,
        PH_DROP
    } phase_t;

    typedef enum logic [1:0] {
        ST_BYTE,
        ST_ADV,
        ST_TRUNC
    } eng_state_t;

    localparam logic [2:0] KIND_NULL  = 3'd0;
    localparam logic [2:0] KIND_INT   = 3'd1;
    localparam logic [2:0] KIND_TEXT  = 3'd2;
    localparam logic [2:0] KIND_EMPTY = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;
    localparam logic [2:0] KIND_ERROR = 3'd5;

    localparam logic [1:0] ERR_TRUNC = 2'd0;
    localparam logic [1:0] ERR_COUNT = 2'd1;
    localparam logic [1:0] ERR_TYPE  = 2'd2;
    localparam logic [1:0] ERR_SPACE = 2'd3;

    localparam logic [1:0] TYPE_INT  = 2'd0;
    localparam logic [1:0] TYPE_TEXT = 2'd1;

    localparam logic [1:0] CFG_COLUMNS_IN_USE = 2'd0;
    localparam logic [1:0] CFG_COLUMN_TYPES   = 2'd1;
    localparam logic [1:0] CFG_TEXT_SPACE     = 2'd2;

    localparam logic [21:0] TEXT_SPACE_RESET = 22'd2097152;

endpackage

`default_nettype wire

/* rtl/row_record_decoder_core.sv */
// ---------------------------------------------------------------------------
// Row record decoder core
// Streams a serialized row byte by byte and emits decoded column results.
// ---------------------------------------------------------------------------
//  channel | signals                                  | dir
//  row     | row_valid, row_stall, row_item           | in
//  res     | res_valid, res_stall, res_item           | out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| in
//
//  The engine takes one byte per cycle while the queue holds a byte, the output
//  slot is free and no null walk or cut-row report is running. A byte may cause
//  several results: one result per cycle while res_stall is low, nulls walked
//  one column per cycle by the engine sequencer.
//  Reset clears all control state at once; no clearing pass.
//  res_stall holds the output register; the queue keeps accepting until full.
// ---------------------------------------------------------------------------
`default_nettype none

module row_record_decoder_core
    import rrd_pkg::*;
#(
    parameter int MAX_COLUMNS = 32,
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        row_valid,
    output logic             row_stall,
    input  wire row_item_t   row_item,
    output logic             res_valid,
    input  wire logic        res_stall,
    output res_item_t        res_item,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    cfg_regs_t  cfg_reg;
    logic       q_valid;
    logic       q_pop;
    row_item_t  q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.columns_in_use <= '0;
            cfg_reg.column_types   <= '0;
            cfg_reg.text_space     <= TEXT_SPACE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COLUMNS_IN_USE: cfg_reg.columns_in_use <= cfg_data[5:0];
                CFG_COLUMN_TYPES:   cfg_reg.column_types   <= cfg_data;
                CFG_TEXT_SPACE:     cfg_reg.text_space     <= cfg_data[21:0];
                default:
                begin
                end
            endcase
        end
    end

    rrd_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(row_item_t))
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (row_valid),
        .wr_stall (row_stall),
        .wr_data  (row_item),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_item)
    );

    rrd_engine #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

`default_nettype wire

/* rtl/rrd_queue.sv */
// ---------------------------------------------------------------------------
// Row record decoder input queue
// Small FIFO that accepts row bytes and decouples them from the decoder.
// ---------------------------------------------------------------------------
`default_nettype none

module rrd_queue
    import rrd_pkg::*;
#(
    parameter int DEPTH = 4,
    parameter int WIDTH = 9
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_stall,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_pop,
    output logic [WIDTH-1:0]      rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push;

    assign wr_stall = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && !wr_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next  = count_reg + CW'(push) - CW'(rd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/rrd_engine.sv */
// ---------------------------------------------------------------------------
// Row record decoder engine
// Decodes queued row bytes into column results, one result per cycle at most, none while res_stall holds the output.
// ---------------------------------------------------------------------------
`default_nettype none

`include "row_record_decoder_core_defines.svh"

module rrd_engine
    import rrd_pkg::*;
#(
    parameter int MAX_COLUMNS = 32
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_regs_t cfg,
    input  wire logic      q_valid,
    input  wire row_item_t q_item,
    output logic           q_pop,
    output logic           res_valid,
    input  wire logic      res_stall,
    output res_item_t      res_item
);

    localparam logic [5:0] MAX_COLS_W = 6'(MAX_COLUMNS);

    eng_state_t             state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [7:0]             header_low_reg, header_low_next;
    logic [MAX_COLUMNS-1:0] null_map_reg, null_map_next;
    logic [5:0]             current_column_reg, current_column_next;
    logic [2:0]             byte_index_reg, byte_index_next;
    logic [31:0]            int_assembly_reg, int_assembly_next;
    logic [15:0]            text_remaining_reg, text_remaining_next;
    logic [15:0]            text_len_reg, text_len_next;
    logic [21:0]            text_space_used_reg, text_space_used_next;
    logic                   eor_reg, eor_next;
    logic                   res_valid_reg, res_valid_next;
    res_item_t              res_item_reg;

    res_item_t              res_d;
    logic                   emit;
    logic                   slot_free;
    logic [5:0]             nc;
    logic [5:0]             nc_plus7;
    logic [2:0]             nbytes;
    logic [7:0]             b;
    logic                   eor;
    logic [2:0]             bi_inc;
    logic [MAX_COLUMNS-1:0] map_merged;
    logic [31:0]            int_merged;
    logic [15:0]            tlen;
    logic [22:0]            space_sum;
    logic [15:0]            rem_dec;

    function automatic logic col_is_null(logic [MAX_COLUMNS-1:0] map, logic [5:0] col);
        logic r;
        r = 1'b0;
        for (int i = 0; i < MAX_COLUMNS; i++)
        begin
            if (col == 6'(i))
            begin
                r = map[i];
            end
        end
        return r;
    endfunction

    function automatic logic [1:0] col_type(logic [63:0] types, logic [5:0] col);
        logic [1:0] r;
        r = 2'd0;
        for (int i = 0; i < MAX_COLUMNS; i++)
        begin
            if (col == 6'(i))
            begin
                r = types[2*i +: 2];
            end
        end
        return r;
    endfunction

    // column needs data bytes: decoding pauses there without a result
    function automatic logic col_stops(logic [MAX_COLUMNS-1:0] map, logic [63:0] types,
                                       logic [5:0] col, logic [5:0] ncols);
        logic [1:0] t;
        t = col_type(types, col);
        return (col < ncols) && !col_is_null(map, col) && (t == TYPE_INT || t == TYPE_TEXT);
    endfunction

    assign slot_free = !res_valid_reg || !res_stall;
    assign nc        = (cfg.columns_in_use > MAX_COLS_W) ? MAX_COLS_W : cfg.columns_in_use;
    assign nc_plus7  = nc + 6'd7;
    assign nbytes    = nc_plus7[5:3];
    assign b         = q_item.row_byte;
    assign eor       = q_item.end_of_row;
    assign bi_inc    = byte_index_reg + 3'd1;
    assign int_merged = int_assembly_reg | (32'(b) << {byte_index_reg[1:0], 3'b000});
    assign tlen      = {b, header_low_reg};
    assign space_sum = {1'b0, text_space_used_reg} + 23'(tlen) + 23'd1;
    assign rem_dec   = text_remaining_reg - 16'd1;

    always_comb
    begin
        for (int i = 0; i < MAX_COLUMNS; i++)
        begin
            map_merged[i] = null_map_reg[i];
            if (3'(i >> 3) == byte_index_reg)
            begin
                map_merged[i] = null_map_reg[i] | b[3'(i & 7)];
            end
        end
    end

    always_comb
    begin
        logic       adv;
        logic       adv_go;
        logic       direct;
        logic       trunc;
        logic       clear;
        logic [1:0] t;

        adv    = 1'b0;
        adv_go = 1'b0;
        direct = 1'b0;
        trunc  = 1'b0;
        clear  = 1'b0;
        t      = 2'd0;

        state_next           = state_reg;
        phase_next           = phase_reg;
        header_low_next      = header_low_reg;
        null_map_next        = null_map_reg;
        current_column_next  = current_column_reg;
        byte_index_next      = byte_index_reg;
        int_assembly_next    = int_assembly_reg;
        text_remaining_next  = text_remaining_reg;
        text_len_next        = text_len_reg;
        text_space_used_next = text_space_used_reg;
        eor_next             = eor_reg;
        res_d                = '0;
        emit                 = 1'b0;
        q_pop                = 1'b0;

        unique case (state_reg)
            ST_BYTE:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop = 1'b1;
                    unique case (phase_reg)
                        PH_HDR_LO:
                        begin
                            header_low_next = b;
                            phase_next      = PH_HDR_HI;
                        end
                        PH_HDR_HI:
                        begin
                            if ({b, header_low_reg} != {10'd0, nc})
                            begin
                                direct           = 1'b1;
                                res_d.result_kind = KIND_ERROR;
                                res_d.error_code = ERR_COUNT;
                                phase_next       = PH_DROP;
                            end
                            else
                            begin
                                null_map_next   = '0;
                                byte_index_next = 3'd0;
                                if (nbytes == 3'd0)
                                begin
                                    adv = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_NULLMAP;
                                end
                            end
                        end
                        PH_NULLMAP:
                        begin
                            null_map_next   = map_merged;
                            byte_index_next = bi_inc;
                            if (bi_inc >= nbytes)
                            begin
                                adv = 1'b1;
                            end
                        end
                        PH_INT:
                        begin
                            int_assembly_next = int_merged;
                            byte_index_next   = bi_inc;
                            if (bi_inc >= 3'd4)
                            begin
                                direct              = 1'b1;
                                res_d.result_kind   = KIND_INT;
                                res_d.column        = current_column_reg[4:0];
                                res_d.int_value     = $signed(int_merged);
                                res_d.column_done   = 1'b1;
                                current_column_next = current_column_reg + 6'd1;
                                adv                 = 1'b1;
                            end
                        end
                        PH_TLEN_LO:
                        begin
                            header_low_next = b;
                            phase_next      = PH_TLEN_HI;
                        end
                        PH_TLEN_HI:
                        begin
                            if (space_sum > {1'b0, cfg.text_space})
                            begin
                                direct            = 1'b1;
                                res_d.result_kind = KIND_ERROR;
                                res_d.column      = current_column_reg[4:0];
                                res_d.error_code  = ERR_SPACE;
                                phase_next        = PH_DROP;
                            end
                            else
                            begin
                                text_space_used_next = space_sum[21:0];
                                text_len_next        = tlen;
                                text_remaining_next  = tlen;
                                if (tlen == 16'd0)
                                begin
                                    direct              = 1'b1;
                                    res_d.result_kind   = KIND_EMPTY;
                                    res_d.column        = current_column_reg[4:0];
                                    res_d.column_done   = 1'b1;
                                    current_column_next = current_column_reg + 6'd1;
                                    adv                 = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_TEXT;
                                end
                            end
                        end
                        PH_TEXT:
                        begin
                            text_remaining_next = rem_dec;
                            direct              = 1'b1;
                            res_d.result_kind   = KIND_TEXT;
                            res_d.column        = current_column_reg[4:0];
                            res_d.text_byte     = b;
                            res_d.text_length   = text_len_reg;
                            res_d.column_done   = (rem_dec == 16'd0);
                            if (rem_dec == 16'd0)
                            begin
                                current_column_next = current_column_reg + 6'd1;
                                adv                 = 1'b1;
                            end
                        end
                        PH_DROP:
                        begin
                        end
                    endcase

                    if (adv)
                    begin
                        if (col_stops(null_map_next, cfg.column_types, current_column_next, nc))
                        begin
                            t = col_type(cfg.column_types, current_column_next);
                            if (t == TYPE_INT)
                            begin
                                phase_next        = PH_INT;
                                byte_index_next   = 3'd0;
                                int_assembly_next = '0;
                            end
                            else
                            begin
                                phase_next = PH_TLEN_LO;
                            end
                        end
                        else
                        begin
                            adv_go = 1'b1;
                        end
                    end

                    if (adv_go)
                    begin
                        emit              = direct;
                        res_d.last_result = 1'b0;
                        eor_next          = eor;
                        state_next        = ST_ADV;
                    end
                    else
                    begin
                        trunc = eor && (phase_next != PH_DROP);
                        if (direct)
                        begin
                            emit              = 1'b1;
                            res_d.last_result = !trunc;
                            if (trunc)
                            begin
                                state_next = ST_TRUNC;
                            end
                            else
                            begin
                                clear = eor;
                            end
                        end
                        else if (trunc)
                        begin
                            emit              = 1'b1;
                            res_d.result_kind = KIND_ERROR;
                            res_d.column      = current_column_next[4:0];
                            res_d.error_code  = ERR_TRUNC;
                            res_d.last_result = 1'b1;
                            clear             = 1'b1;
                        end
                        else
                        begin
                            clear = eor;
                        end
                    end
                end
            end
            ST_ADV:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (current_column_reg >= nc)
                    begin
                        res_d.result_kind = KIND_DONE;
                        res_d.last_result = 1'b1;
                        phase_next        = PH_DROP;
                        state_next        = ST_BYTE;
                        clear             = eor_reg;
                    end
                    else if (col_is_null(null_map_reg, current_column_reg))
                    begin
                        res_d.result_kind   = KIND_NULL;
                        res_d.column        = current_column_reg[4:0];
                        res_d.column_done   = 1'b1;
                        current_column_next = current_column_reg + 6'd1;
                        if (col_stops(null_map_reg, cfg.column_types, current_column_next, nc))
                        begin
                            t = col_type(cfg.column_types, current_column_next);
                            if (t == TYPE_INT)
                            begin
                                phase_next        = PH_INT;
                                byte_index_next   = 3'd0;
                                int_assembly_next = '0;
                            end
                            else
                            begin
                                phase_next = PH_TLEN_LO;
                            end
                            res_d.last_result = !eor_reg;
                            state_next        = eor_reg ? ST_TRUNC : ST_BYTE;
                        end
                    end
                    else
                    begin
                        res_d.result_kind = KIND_ERROR;
                        res_d.column      = current_column_reg[4:0];
                        res_d.error_code  = ERR_TYPE;
                        res_d.last_result = 1'b1;
                        phase_next        = PH_DROP;
                        state_next        = ST_BYTE;
                        clear             = eor_reg;
                    end
                end
            end
            ST_TRUNC:
            begin
                if (slot_free)
                begin
                    emit              = 1'b1;
                    res_d.result_kind = KIND_ERROR;
                    res_d.column      = current_column_reg[4:0];
                    res_d.error_code  = ERR_TRUNC;
                    res_d.last_result = 1'b1;
                    state_next        = ST_BYTE;
                    clear             = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_BYTE;
            end
        endcase

        // row boundary
        if (clear)
        begin
            phase_next           = PH_HDR_LO;
            header_low_next      = '0;
            null_map_next        = '0;
            current_column_next  = '0;
            byte_index_next      = '0;
            int_assembly_next    = '0;
            text_remaining_next  = '0;
            text_space_used_next = '0;
            text_len_next        = '0;
            eor_next             = 1'b0;
        end

        res_valid_next = emit ? 1'b1 : (res_stall ? res_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_BYTE;
            phase_reg           <= PH_HDR_LO;
            header_low_reg      <= '0;
            null_map_reg        <= '0;
            current_column_reg  <= '0;
            byte_index_reg      <= '0;
            int_assembly_reg    <= '0;
            text_remaining_reg  <= '0;
            text_len_reg        <= '0;
            text_space_used_reg <= '0;
            eor_reg             <= 1'b0;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            phase_reg           <= phase_next;
            header_low_reg      <= header_low_next;
            null_map_reg        <= null_map_next;
            current_column_reg  <= current_column_next;
            byte_index_reg      <= byte_index_next;
            int_assembly_reg    <= int_assembly_next;
            text_remaining_reg  <= text_remaining_next;
            text_len_reg        <= text_len_next;
            text_space_used_reg <= text_space_used_next;
            eor_reg             <= eor_next;
            res_valid_reg       <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_item_reg <= res_d;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    `RRD_ASSERT_NEXT(a_partial_keeps_busy, clk, rst_n, emit && !res_d.last_result, state_reg != ST_BYTE)
    `RRD_ASSERT(a_column_bound, clk, rst_n, current_column_reg <= MAX_COLS_W)
    `RRD_ASSERT_NEXT(a_done_ends_row, clk, rst_n, emit && res_d.result_kind == KIND_DONE, phase_reg == PH_DROP || phase_reg == PH_HDR_LO)

endmodule

`default_nettype wire

/* sim/row_record_decoder_core_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Row record decoder testbench
// Streams directed and random serialized rows into the decoder while
// reprogramming the schema registers. A scoreboard decodes every accepted
// byte in parallel and checks each result transaction in order. Both
// channels idle at random.
// ---------------------------------------------------------------------------

module testbench;
    import rrd_pkg::*;

    localparam int MAX_COLS       = 32;
    localparam int IDLE_PCT       = 12;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES   = 72;
    localparam int PHASE_BYTES    = 12;
    localparam int REPORT_MAX     = 10;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    class row_scoreboard;
        logic [5:0]  cols_cfg;
        logic [63:0] types_cfg;
        logic [21:0] space_cfg;

        phase_t      ph;
        logic [7:0]  low_byte;
        logic [31:0] nulls;
        logic [5:0]  col;
        logic [2:0]  bidx;
        logic [31:0] acc;
        logic [15:0] remaining;
        logic [21:0] used;
        logic [15:0] tlen;

        res_item_t   expected_q[$];
        int          fails;
        int          reported;
        int          checked;

        function new();
            cols_cfg  = '0;
            types_cfg = '0;
            space_cfg = TEXT_SPACE_RESET;
            fails     = 0;
            reported  = 0;
            checked   = 0;
            clear_row();
        endfunction

        function void clear_row();
            ph        = PH_HDR_LO;
            low_byte  = '0;
            nulls     = '0;
            col       = '0;
            bidx      = '0;
            acc       = '0;
            remaining = '0;
            used      = '0;
            tlen      = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void apply_write(logic [1:0] idx, logic [63:0] data);
            case (idx)
                CFG_COLUMNS_IN_USE: cols_cfg  = data[5:0];
                CFG_COLUMN_TYPES:   types_cfg = data;
                CFG_TEXT_SPACE:     space_cfg = data[21:0];
                default: ;
            endcase
        endfunction

        function logic [5:0] eff_cols();
            return (cols_cfg > MAX_COLS) ? 6'(MAX_COLS) : cols_cfg;
        endfunction

        function void emit(logic [2:0] kind, logic [4:0] c, logic [31:0] iv,
                           logic [7:0] tb, logic [15:0] tl, logic done,
                           logic [1:0] ec);
            res_item_t r;
            r.result_kind = kind;
            r.column      = c;
            r.int_value   = iv;
            r.text_byte   = tb;
            r.text_length = tl;
            r.column_done = done;
            r.error_code  = ec;
            r.last_result = 1'b0;
            expected_q.push_back(r);
        endfunction

        // report nulls until a column needs bytes or has a bad type, or close the row
        function void walk_columns();
            logic [5:0] nc;
            logic [4:0] c;
            logic [1:0] t;
            nc = eff_cols();
            while (col < nc) begin
                c = col[4:0];
                if (nulls[c]) begin
                    emit(KIND_NULL, c, '0, '0, '0, 1'b1, '0);
                    col = col + 1'b1;
                    continue;
                end
                t = types_cfg[2*c +: 2];
                if (t == TYPE_INT) begin
                    ph   = PH_INT;
                    bidx = '0;
                    acc  = '0;
                end else if (t == TYPE_TEXT) begin
                    ph = PH_TLEN_LO;
                end else begin
                    emit(KIND_ERROR, c, '0, '0, '0, 1'b0, ERR_TYPE);
                    ph = PH_DROP;
                end
                return;
            end
            emit(KIND_DONE, '0, '0, '0, '0, 1'b0, '0);
            ph = PH_DROP;
        endfunction

        function void decode_byte(row_item_t it);
            logic [7:0]  b;
            logic [5:0]  nc;
            logic [2:0]  nbytes;
            logic [31:0] len;
            logic        done;
            int          first;
            b      = it.row_byte;
            nc     = eff_cols();
            nbytes = 3'((nc + 7) / 8);
            first  = expected_q.size();
            case (ph)
                PH_HDR_LO: begin
                    low_byte = b;
                    ph       = PH_HDR_HI;
                end
                PH_HDR_HI: begin
                    if ({b, low_byte} != 16'(nc)) begin
                        emit(KIND_ERROR, '0, '0, '0, '0, 1'b0, ERR_COUNT);
                        ph = PH_DROP;
                    end else begin
                        nulls = '0;
                        bidx  = '0;
                        if (nbytes == 0) walk_columns();
                        else ph = PH_NULLMAP;
                    end
                end
                PH_NULLMAP: begin
                    if (bidx < 4) nulls = nulls | (32'(b) << (8 * bidx));
                    bidx = bidx + 1'b1;
                    if (bidx >= nbytes) walk_columns();
                end
                PH_INT: begin
                    acc  = acc | (32'(b) << (8 * bidx[1:0]));
                    bidx = bidx + 1'b1;
                    if (bidx >= 4) begin
                        emit(KIND_INT, col[4:0], acc, '0, '0, 1'b1, '0);
                        col = col + 1'b1;
                        walk_columns();
                    end
                end
                PH_TLEN_LO: begin
                    low_byte = b;
                    ph       = PH_TLEN_HI;
                end
                PH_TLEN_HI: begin
                    len = 32'({b, low_byte});
                    if (32'(used) + len + 1 > 32'(space_cfg)) begin
                        emit(KIND_ERROR, col[4:0], '0, '0, '0, 1'b0, ERR_SPACE);
                        ph = PH_DROP;
                    end else begin
                        used      = used + 22'(len + 1);
                        tlen      = len[15:0];
                        remaining = len[15:0];
                        if (len == 0) begin
                            emit(KIND_EMPTY, col[4:0], '0, '0, '0, 1'b1, '0);
                            col = col + 1'b1;
                            walk_columns();
                        end else begin
                            ph = PH_TEXT;
                        end
                    end
                end
                PH_TEXT: begin
                    remaining = remaining - 1'b1;
                    done      = (remaining == 0);
                    emit(KIND_TEXT, col[4:0], '0, b, tlen, done, '0);
                    if (done) begin
                        col = col + 1'b1;
                        walk_columns();
                    end
                end
                default: ;
            endcase
            if (it.end_of_row) begin
                if (ph != PH_DROP) emit(KIND_ERROR, col[4:0], '0, '0, '0, 1'b0, ERR_TRUNC);
                clear_row();
            end
            if (expected_q.size() > first)
                expected_q[expected_q.size() - 1].last_result = 1'b1;
        endfunction

        function void check_result(res_item_t got);
            res_item_t want;
            logic      bad;
            checked++;
            if (expected_q.size() == 0) begin
                fails++;
                if (reported < REPORT_MAX)
                    $display("unexpected result: kind %0d col %0d int %0d byte %0h len %0d",
                             got.result_kind, got.column, got.int_value, got.text_byte,
                             got.text_length);
                reported++;
                return;
            end
            want = expected_q.pop_front();
            bad = (got.result_kind !== want.result_kind) ||
                  (got.column      !== want.column)      ||
                  (got.int_value   !== want.int_value)   ||
                  (got.text_byte   !== want.text_byte)   ||
                  (got.text_length !== want.text_length) ||
                  (got.column_done !== want.column_done) ||
                  (got.error_code  !== want.error_code)  ||
                  (got.last_result !== want.last_result);
            if (bad) begin
                fails++;
                if (reported < REPORT_MAX) begin
                    $display("mismatch at result %0d", checked);
                    $display("  expected kind %0d col %0d int %0d byte %0h len %0d",
                             want.result_kind, want.column, want.int_value,
                             want.text_byte, want.text_length);
                    $display("           done %0b err %0d last %0b",
                             want.column_done, want.error_code, want.last_result);
                    $display("  actual   kind %0d col %0d int %0d byte %0h len %0d",
                             got.result_kind, got.column, got.int_value,
                             got.text_byte, got.text_length);
                    $display("           done %0b err %0d last %0b",
                             got.column_done, got.error_code, got.last_result);
                end
                reported++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        row_valid = 1'b0;
    logic        row_stall;
    row_item_t   row_item  = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_item_t   res_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;

    row_scoreboard sb = new();

    bit          calm = 1'b0;
    int          quiet_cycles = 0;
    int          bytes_in = 0;
    int          settings = 0;
    logic [7:0]  row_q[$];
    logic [5:0]  cur_cols  = '0;
    logic [63:0] cur_types = '0;

    row_record_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_valid (row_valid),
        .row_stall (row_stall),
        .row_item  (row_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        res_stall <= rst_n && !calm && ($urandom_range(0, 99) < IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready) sb.apply_write(cfg_index, cfg_data);
            if (row_valid && !row_stall)
            begin
                sb.decode_byte(row_item);
                bytes_in++;
            end
            if (res_valid && !res_stall) sb.check_result(res_item);
            if ((cfg_valid && cfg_ready) || (row_valid && !row_stall) ||
                (res_valid && !res_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, sb.pending());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // leaves row_valid high at a falling edge; the next caller reassigns it
    task automatic send_item(input logic [7:0] b, input logic eor);
        while (!calm && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            row_valid <= 1'b0;
            @(negedge clk);
        end
        row_valid <= 1'b1;
        row_item  <= '{row_byte: b, end_of_row: eor};
        do @(posedge clk); while (row_stall);
        @(negedge clk);
    endtask

    task automatic send_queued(input bit close);
        for (int i = 0; i < row_q.size(); i++)
            send_item(row_q[i], close && (i == row_q.size() - 1));
    endtask

    task automatic settle();
        row_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic program_regs(input logic [5:0] cols, input logic [63:0] types,
                                input logic [21:0] space, input bit spare);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(CFG_COLUMNS_IN_USE, {junk[63:6], cols});
        write_reg(CFG_COLUMN_TYPES, types);
        write_reg(CFG_TEXT_SPACE, {junk[63:22], space});
        if (spare) write_reg(CFG_UNUSED, {$urandom, $urandom});
        cfg_valid <= 1'b0;
        cur_cols  = cols;
        cur_types = types;
        settings++;
    endtask

    function automatic logic [63:0] mixed_types();
        logic [63:0] t;
        int          r;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            r = $urandom_range(0, 99);
            t[2*c +: 2] = (r < 45) ? TYPE_INT : (r < 90) ? TYPE_TEXT :
                          2'($urandom_range(2, 3));
        end
        return t;
    endfunction

    function automatic logic [31:0] pick_int();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // mostly well-formed rows; some cut short, some with a bad count, some noise
    task automatic send_random_row(output int sent);
        int          roll;
        int          nc;
        int          len;
        int          cut;
        logic [15:0] cnt;
        logic [31:0] nmask;
        logic [31:0] v;
        logic [1:0]  t;
        row_q = {};
        nc    = (cur_cols > MAX_COLS) ? MAX_COLS : cur_cols;
        roll  = $urandom_range(0, 99);
        if (roll >= 92)
        begin
            repeat ($urandom_range(1, 6)) row_q.push_back(8'($urandom));
        end
        else
        begin
            cnt = 16'(nc);
            if (roll >= 85) cnt = cnt ^ (16'd1 << $urandom_range(0, 15));
            row_q.push_back(cnt[7:0]);
            row_q.push_back(cnt[15:8]);
            if (nc > 12) nmask = $urandom | $urandom | $urandom;
            else nmask = $urandom & $urandom;
            for (int i = 0; i < (nc + 7) / 8; i++) row_q.push_back(nmask[8*i +: 8]);
            for (int c = 0; c < nc; c++)
            begin
                if (nmask[c]) continue;
                t = cur_types[2*c +: 2];
                if (t == TYPE_INT)
                begin
                    v = pick_int();
                    for (int k = 0; k < 4; k++) row_q.push_back(v[8*k +: 8]);
                end
                else if (t == TYPE_TEXT)
                begin
                    len = ($urandom_range(0, 99) < 4) ? $urandom_range(256, 300) :
                                                        $urandom_range(0, 5);
                    row_q.push_back(8'(len));
                    row_q.push_back(8'(len >> 8));
                    // long lengths end the column data right after the length bytes
                    if (len > 255) break;
                    repeat (len) row_q.push_back(8'($urandom));
                end
                else
                    break;
            end
            if (roll >= 75 && roll < 85 && row_q.size() > 1)
            begin
                cut = $urandom_range(1, row_q.size() - 1);
                while (row_q.size() > cut) void'(row_q.pop_back());
            end
            else if ($urandom_range(0, 99) < 20)
                repeat ($urandom_range(1, 3)) row_q.push_back(8'($urandom));
        end
        send_queued(1'b1);
        sent = row_q.size();
    endtask

    initial
    begin
        int          random_bytes;
        int          phase_bytes;
        int          sent;
        int          p;
        logic [5:0]  cols;
        logic [63:0] types;
        logic [21:0] space;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset schema: zero columns, then bad count and an early row end
        row_q = {8'h00, 8'h00};
        send_queued(1'b1);
        row_q = {8'h01, 8'h00};
        send_queued(1'b1);
        row_q = {8'h00};
        send_queued(1'b1);

        // int, text, then a text that overruns a tight text space
        settle();
        program_regs(6'd3, 64'h14, 22'd4, 1'b0);
        row_q = {8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
                 8'h02, 8'h00, 8'h61, 8'h62, 8'h01, 8'h00};
        send_queued(1'b1);
        // nulls around an empty text
        row_q = {8'h03, 8'h00, 8'h05, 8'h00, 8'h00};
        send_queued(1'b1);

        // type change mid-row, applied before the next column starts
        row_q = {8'h03, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff};
        send_queued(1'b0);
        settle();
        write_reg(CFG_COLUMN_TYPES, 64'h3c);
        cfg_valid <= 1'b0;
        cur_types = 64'h3c;
        row_q = {8'h7f};
        send_queued(1'b1);

        // oversized count clamps; all-null row ignores invalid types
        settle();
        program_regs(6'd40, 64'hffff_ffff_ffff_ffff, TEXT_SPACE_RESET, 1'b0);
        row_q = {8'h20, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff};
        send_queued(1'b1);

        random_bytes = 0;
        p = 0;
        while (random_bytes < RANDOM_BYTES || p < 6)
        begin
            settle();
            calm = 1'b0;
            case (p % 6)
                0:
                begin
                    cols  = 6'd32;
                    types = mixed_types();
                    space = TEXT_SPACE_RESET;
                end
                1:
                begin
                    cols  = 6'($urandom_range(1, 6));
                    types = 64'hffff_ffff_ffff_ffff;
                    space = 22'($urandom_range(0, 2097152));
                end
                2:
                begin
                    cols  = 6'($urandom_range(1, 8));
                    types = mixed_types();
                    space = 22'($urandom_range(0, 40));
                    calm  = 1'b1;
                end
                3:
                begin
                    cols  = 6'd63;
                    types = 64'h0;
                    space = TEXT_SPACE_RESET;
                end
                4:
                begin
                    cols  = 6'($urandom_range(9, 31));
                    types = mixed_types();
                    space = 22'($urandom_range(0, 2097152));
                end
                default:
                begin
                    cols  = 6'($urandom_range(1, 4));
                    types = 64'h5555_5555_5555_5555;
                    space = 22'd0;
                end
            endcase
            program_regs(cols, types, space, p == 0);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                send_random_row(sent);
                phase_bytes += sent;
            end
            random_bytes += phase_bytes;
            p++;
        end

        settle();
        calm = 1'b0;
        $display("Decoded %0d row bytes under %0d register settings, %0d results checked.",
                 bytes_in, settings, sb.checked);
        $display("Rows mixed nulls, ints, texts, bad counts, bad types, space overruns and cuts.");
        if (sb.fails == 0)
            $display("== PASS ==");
        else
        begin
            $display("%0d mismatching results", sb.fails);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
